// ===== rtl/m61rh_pkg.sv =====
// ----------------------------------------------------------------------------
// m61rh_pkg
// Shared types and constants for the base-256 rolling hash modulo 2^61-1.
// ----------------------------------------------------------------------------
package m61rh_pkg;

    localparam int RES_W   = 61;
    localparam int OPV_W   = 64;
    localparam int BYTE_W  = 8;
    localparam int KCNT_W  = 20;
    localparam int SHAMT_W = 6;

    localparam logic [RES_W-1:0] MOD_M = {RES_W{1'b1}};

    typedef enum logic [2:0] {
        ACT_CLEAR    = 3'd0,
        ACT_APPEND   = 3'd1,
        ACT_LOAD     = 3'd2,
        ACT_ADD      = 3'd3,
        ACT_SUB      = 3'd4,
        ACT_MUL_BYTE = 3'd5,
        ACT_SHIFT    = 3'd6,
        ACT_COMPARE  = 3'd7
    } action_t;

    // One prepared beat: operand already reduced, shift amount already mod 61.
    typedef struct packed {
        action_t              action;
        logic [RES_W-1:0]     operand;
        logic [BYTE_W-1:0]    byte_val;
        logic [SHAMT_W-1:0]   shamt;
    } item_t;

endpackage

// ===== rtl/m61rh_prep.sv =====
// ----------------------------------------------------------------------------
// m61rh_prep
// Accumulator-independent front end: folds the 64-bit operand to a residue
// and turns the byte power k into a rotate amount (8k mod 61).
// ----------------------------------------------------------------------------
module m61rh_prep (
    input  m61rh_pkg::action_t                 action,
    input  logic [m61rh_pkg::OPV_W-1:0]        operand_value,
    input  logic [m61rh_pkg::BYTE_W-1:0]       byte_value,
    input  logic [m61rh_pkg::KCNT_W-1:0]       byte_shift_count,
    output m61rh_pkg::item_t                   item
);
    import m61rh_pkg::*;

    localparam int X_W = KCNT_W + 3;
    localparam int RECIP_W = 25;
    localparam int RECIP_SH = 30;
    localparam int PROD_W = X_W + RECIP_W;
    localparam int Q_W = PROD_W - RECIP_SH;
    // floor(2^30 / 61): quotient comes out exact or one low
    localparam logic [RECIP_W-1:0] RECIP61 = RECIP_W'((64'd1 << RECIP_SH) / 64'd61);
    localparam logic [6:0] SIXTY_ONE = 7'd61;

    logic [RES_W:0]      fold_sum;
    logic [RES_W-1:0]    opf;
    logic [X_W-1:0]      x;
    logic [PROD_W-1:0]   prod;
    logic [Q_W-1:0]      q;
    logic [X_W-1:0]      qm;
    logic [X_W-1:0]      rem_wide;
    logic [6:0]          rem;
    logic [6:0]          rem_fix;

    always_comb begin
        fold_sum = {1'b0, operand_value[RES_W-1:0]}
                 + {{(RES_W+1-(OPV_W-RES_W)){1'b0}}, operand_value[OPV_W-1:RES_W]};
        if (fold_sum >= {1'b0, MOD_M}) begin
            fold_sum = fold_sum - {1'b0, MOD_M};
        end
        opf = fold_sum[RES_W-1:0];

        x        = {byte_shift_count, 3'b000};
        prod     = {{RECIP_W{1'b0}}, x} * {{X_W{1'b0}}, RECIP61};
        q        = prod[PROD_W-1:RECIP_SH];
        qm       = X_W'({{(X_W+7-Q_W){1'b0}}, q} * {{X_W{1'b0}}, SIXTY_ONE});
        rem_wide = x - qm;
        rem      = rem_wide[6:0];
        rem_fix  = (rem >= SIXTY_ONE) ? (rem - SIXTY_ONE) : rem;

        item.action   = action;
        item.operand  = opf;
        item.byte_val = byte_value;
        item.shamt    = rem_fix[SHAMT_W-1:0];
    end

endmodule

// ===== rtl/m61rh_alu.sv =====
// ----------------------------------------------------------------------------
// m61rh_alu
// Single-pass update of the accumulator residue for one prepared beat.
// ----------------------------------------------------------------------------
module m61rh_alu (
    input  logic [m61rh_pkg::RES_W-1:0]  acc,
    input  m61rh_pkg::item_t             item,
    output logic [m61rh_pkg::RES_W-1:0]  acc_next,
    output logic                         is_equal
);
    import m61rh_pkg::*;

    localparam int PB_W = RES_W + BYTE_W;

    logic [RES_W:0]       app_sum;
    logic [RES_W:0]       add_sum;
    logic [RES_W:0]       sub_sum;
    logic [PB_W-1:0]      pb;
    logic [RES_W:0]       mul_sum;
    logic [2*RES_W-1:0]   rot_wide;
    logic [RES_W-1:0]     app_res;
    logic [RES_W-1:0]     add_res;
    logic [RES_W-1:0]     sub_res;
    logic [RES_W-1:0]     mul_res;

    always_comb begin
        // acc*256 + c: low 53 bits move up, top 8 bits wrap around
        app_sum = {1'b0, acc[RES_W-BYTE_W-1:0], item.byte_val}
                + {{(RES_W+1-BYTE_W){1'b0}}, acc[RES_W-1:RES_W-BYTE_W]};
        app_res = (app_sum >= {1'b0, MOD_M}) ? RES_W'(app_sum - {1'b0, MOD_M})
                                             : app_sum[RES_W-1:0];

        add_sum = {1'b0, acc} + {1'b0, item.operand};
        add_res = (add_sum >= {1'b0, MOD_M}) ? RES_W'(add_sum - {1'b0, MOD_M})
                                             : add_sum[RES_W-1:0];

        sub_sum = {1'b0, acc} - {1'b0, item.operand};
        sub_res = (acc >= item.operand) ? sub_sum[RES_W-1:0]
                                        : RES_W'(sub_sum + {1'b0, MOD_M});

        pb      = {{BYTE_W{1'b0}}, acc} * {{RES_W{1'b0}}, item.byte_val};
        mul_sum = {1'b0, pb[RES_W-1:0]} + {{(RES_W+1-BYTE_W){1'b0}}, pb[PB_W-1:RES_W]};
        mul_res = (mul_sum >= {1'b0, MOD_M}) ? RES_W'(mul_sum - {1'b0, MOD_M})
                                             : mul_sum[RES_W-1:0];

        // times 2^r mod 2^61-1 is a 61-bit rotate left
        rot_wide = {acc, acc} << item.shamt;

        is_equal = 1'b0;
        case (item.action)
            ACT_CLEAR:    acc_next = '0;
            ACT_APPEND:   acc_next = app_res;
            ACT_LOAD:     acc_next = item.operand;
            ACT_ADD:      acc_next = add_res;
            ACT_SUB:      acc_next = sub_res;
            ACT_MUL_BYTE: acc_next = mul_res;
            ACT_SHIFT:    acc_next = rot_wide[2*RES_W-1:RES_W];
            ACT_COMPARE: begin
                acc_next = acc;
                is_equal = (acc == item.operand);
            end
            default:      acc_next = acc;
        endcase
    end

endmodule

// ===== rtl/mersenne61_rolling_hash_unit_top.sv =====
// ----------------------------------------------------------------------------
// mersenne61_rolling_hash_unit_top
// Base-256 polynomial hash accumulator modulo 2^61-1.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream s_*: one beat per action. s_tuser carries the action code;
//   s_tdata carries operand_value, byte_value and byte_shift_count.
//   Output stream m_*: exactly one beat per input beat, in order, carrying
//   the accumulator after that action and the compare flag.
//   A string hash is a clear beat followed by one append beat per byte.
// Path: an accepted beat is held in the input register, its result in the
//   output register. Throughput: one beat per cycle while m_tready is high.
//   The accumulator loop closes through the update logic in m61rh_alu;
//   operand folding and rotate amount are done before the input register.
// Reset: aresetn low for one edge empties both stages and sets the
//   accumulator to 1.
// Stall: with m_tready low the result holds in the output register and one
//   more beat is taken if the input register is empty; s_tready then drops.
// ----------------------------------------------------------------------------
module mersenne61_rolling_hash_unit_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [63:0] operand_value, [71:64] byte_value, [91:72] byte_shift_count,
    // [95:92] zero
    input  logic [95:0] s_tdata,
    // [2:0] action
    input  logic [2:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [60:0] residue, [61] is_equal, [63:62] zero
    output logic [63:0] m_tdata
);
    import m61rh_pkg::*;

    item_t              prep_item;
    item_t              s1_item_reg;
    logic               s1_valid_reg;
    logic               s1_valid_next;
    logic [RES_W-1:0]   acc_reg;
    logic [RES_W-1:0]   acc_next;
    logic               eq_next;
    logic               m_valid_reg;
    logic               m_valid_next;
    logic [RES_W-1:0]   m_res_reg;
    logic               m_eq_reg;
    logic               out_ready;
    logic               s1_fire;
    logic               s_fire;

    m61rh_prep u_prep (
        .action           (action_t'(s_tuser)),
        .operand_value    (s_tdata[63:0]),
        .byte_value       (s_tdata[71:64]),
        .byte_shift_count (s_tdata[91:72]),
        .item             (prep_item)
    );

    m61rh_alu u_alu (
        .acc      (acc_reg),
        .item     (s1_item_reg),
        .acc_next (acc_next),
        .is_equal (eq_next)
    );

    always_comb begin
        out_ready     = !m_valid_reg || m_tready;
        s1_fire       = s1_valid_reg && out_ready;
        s_tready      = !s1_valid_reg || out_ready;
        s_fire        = s_tvalid && s_tready;
        s1_valid_next = s_fire ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_reg);
        m_valid_next  = s1_fire ? 1'b1 : (m_tready ? 1'b0 : m_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            acc_reg      <= RES_W'(1);
        end else begin
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= m_valid_next;
            if (s1_fire) begin
                acc_reg <= acc_next;
            end
        end
    end

    // payload: no reset, load on the beat
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            s1_item_reg <= prep_item;
        end
        if (s1_fire) begin
            m_res_reg <= acc_next;
            m_eq_reg  <= eq_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {2'b00, m_eq_reg, m_res_reg};

endmodule

// ===== verif/m61rh_hash_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// m61rh_hash_checker
// Watches both streams of the rolling hash unit. Every accepted input beat
// updates a local copy of the residue and queues the expected output beat.
// Every accepted output beat is checked against the oldest entry.
// ----------------------------------------------------------------------------
module m61rh_hash_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    // [63:0] operand_value, [71:64] byte_value, [91:72] byte_shift_count,
    // [95:92] zero
    input  logic [95:0] s_tdata,
    // [2:0] action
    input  logic [2:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    // [60:0] residue, [61] is_equal, [63:62] zero
    input  logic [63:0] m_tdata,
    output int          fail_count,
    output int          outstanding
);
    import m61rh_pkg::*;

    typedef struct packed {
        logic [RES_W-1:0] residue;
        logic             is_equal;
    } hash_out_t;

    logic [RES_W-1:0] hash_residue;
    hash_out_t        residue_queue[$];

    // Fold any value below 2^128 into a canonical residue; 2^61 = 1 mod M.
    function automatic logic [RES_W-1:0] mod_m61(input logic [127:0] v);
        logic [62:0] s;
        logic [61:0] t;
        s = {2'b00, v[60:0]} + {2'b00, v[121:61]} + {57'd0, v[127:122]};
        t = {1'b0, s[60:0]} + {60'd0, s[62:61]};
        if (t >= {1'b0, MOD_M}) begin
            t = t - {1'b0, MOD_M};
        end
        return t[RES_W-1:0];
    endfunction

    function automatic hash_out_t apply_action(input logic [RES_W-1:0] acc,
                                               input action_t act,
                                               input logic [OPV_W-1:0] opv,
                                               input logic [BYTE_W-1:0] bv,
                                               input logic [KCNT_W-1:0] kcnt);
        hash_out_t   r;
        logic [127:0] wide_acc;
        logic [RES_W-1:0] opv_red;
        int          rot;
        wide_acc   = {67'd0, acc};
        opv_red    = mod_m61({64'd0, opv});
        rot        = (int'(kcnt) * 8) % 61;
        r.residue  = acc;
        r.is_equal = 1'b0;
        case (act)
            ACT_CLEAR:    r.residue = '0;
            ACT_APPEND:   r.residue = mod_m61((wide_acc << 8) | {120'd0, bv});
            ACT_LOAD:     r.residue = opv_red;
            ACT_ADD:      r.residue = mod_m61(wide_acc + {67'd0, opv_red});
            ACT_SUB:      r.residue = mod_m61(wide_acc + {67'd0, MOD_M} - {67'd0, opv_red});
            ACT_MUL_BYTE: r.residue = mod_m61(wide_acc * {120'd0, bv});
            ACT_SHIFT:    r.residue = mod_m61(wide_acc << rot);
            default:      r.is_equal = (acc == opv_red);
        endcase
        return r;
    endfunction

    always @(posedge aclk) begin
        hash_out_t exp_beat;
        hash_out_t new_beat;
        bit        mismatch;
        if (!aresetn) begin
            hash_residue = 1;
            residue_queue.delete();
            fail_count  <= 0;
        end else begin
            // Check the output side first: a result never leaves on the edge
            // that takes its input.
            if (m_tvalid && m_tready) begin
                if (residue_queue.size() == 0) begin
                    $error("output beat with nothing expected: residue %0h is_equal %0b",
                           m_tdata[60:0], m_tdata[61]);
                    fail_count <= fail_count + 1;
                end else begin
                    exp_beat = residue_queue.pop_front();
                    mismatch = 1'b0;
                    if (m_tdata[60:0] !== exp_beat.residue) begin
                        $error("residue: expected %0h actual %0h",
                               exp_beat.residue, m_tdata[60:0]);
                        mismatch = 1'b1;
                    end
                    if (m_tdata[61] !== exp_beat.is_equal) begin
                        $error("is_equal: expected %0b actual %0b",
                               exp_beat.is_equal, m_tdata[61]);
                        mismatch = 1'b1;
                    end
                    if (mismatch) begin
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                new_beat = apply_action(hash_residue, action_t'(s_tuser), s_tdata[63:0],
                                        s_tdata[71:64], s_tdata[91:72]);
                hash_residue = new_beat.residue;
                residue_queue.push_back(new_beat);
            end
        end
        outstanding <= residue_queue.size();
    end

endmodule

// ===== verif/mersenne61_rolling_hash_unit_top_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mersenne61_rolling_hash_unit_top_tb
// Drives the rolling hash unit with directed actions, then random string
// hashes, load/compare runs and single actions, with random idle bursts on
// both streams. The checker predicts every output beat and counts errors.
// ----------------------------------------------------------------------------
module mersenne61_rolling_hash_unit_top_tb;
    import m61rh_pkg::*;

    localparam int RANDOM_ITEMS = 700;
    localparam int QUIET_ITEMS  = 80;
    localparam int CYCLE_LIMIT  = 200000;

    localparam logic [63:0] M64    = {3'b000, MOD_M};
    localparam logic [63:0] ALL1   = {64{1'b1}};

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [95:0] s_tdata  = '0;
    logic [2:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;

    int fail_count;
    int outstanding;
    int sent_count  = 0;
    int cycle_count = 0;
    bit quiet       = 1'b0;
    bit send_gaps   = 1'b1;
    bit recv_gaps   = 1'b1;
    int recv_hold   = 0;

    mersenne61_rolling_hash_unit_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    m61rh_hash_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Output side back-pressure: random stall bursts, stretches without any.
    always @(posedge aclk) begin
        if ($urandom_range(0, 39) == 0) begin
            recv_gaps <= ~recv_gaps;
        end
        if (quiet) begin
            m_tready <= 1'b1;
        end else if (recv_hold > 0) begin
            recv_hold <= recv_hold - 1;
            m_tready  <= 1'b0;
        end else if (recv_gaps && $urandom_range(0, 3) == 0) begin
            recv_hold <= $urandom_range(0, 6);
            m_tready  <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    task automatic send_beat(input action_t act, input logic [63:0] opv,
                             input logic [7:0] bv, input logic [19:0] kcnt);
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {4'd0, kcnt, bv, opv};
        do @(posedge aclk); while (!s_tready);
        sent_count++;
        if (!quiet && send_gaps && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge aclk);
        end
    endtask

    // Hold off the input until every queued result has left.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
    endtask

    function automatic logic [63:0] rand_operand();
        logic [63:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 5))
            0:       rand_operand = v;
            1:       rand_operand = {3'b000, v[60:0]};
            2:       rand_operand = M64 - $urandom_range(0, 3);
            3:       rand_operand = M64 + $urandom_range(0, 3);
            4:       rand_operand = ALL1 - $urandom_range(0, 3);
            default: rand_operand = $urandom_range(0, 300);
        endcase
    endfunction

    task automatic send_random_action();
        action_t act;
        act = action_t'($urandom_range(0, 7));
        send_beat(act, rand_operand(), 8'($urandom), 20'($urandom));
    endtask

    initial begin
        int n;
        logic [63:0] v;
        logic [63:0] w;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: reset value, extremes of every field, non-canonical operands.
        send_beat(ACT_COMPARE,  64'd1, 8'd0, 20'd0);
        send_beat(ACT_APPEND,   64'd0, 8'hFF, 20'd0);
        send_beat(ACT_CLEAR,    ALL1, 8'hFF, 20'hFFFFF);
        send_beat(ACT_COMPARE,  M64, 8'd0, 20'd0);
        send_beat(ACT_APPEND,   64'd0, 8'h61, 20'd0);
        send_beat(ACT_APPEND,   64'd0, 8'h62, 20'd0);
        send_beat(ACT_APPEND,   64'd0, 8'h63, 20'd0);
        send_beat(ACT_LOAD,     ALL1, 8'd0, 20'd0);
        send_beat(ACT_LOAD,     M64, 8'd0, 20'd0);
        send_beat(ACT_LOAD,     M64 - 64'd1, 8'd0, 20'd0);
        send_beat(ACT_APPEND,   64'd0, 8'hFF, 20'd0);
        send_beat(ACT_LOAD,     M64 - 64'd1, 8'd0, 20'd0);
        send_beat(ACT_ADD,      M64 - 64'd1, 8'd0, 20'd0);
        send_beat(ACT_ADD,      M64, 8'd0, 20'd0);
        send_beat(ACT_ADD,      ALL1, 8'd0, 20'd0);
        send_beat(ACT_SUB,      ALL1, 8'd0, 20'd0);
        send_beat(ACT_SUB,      M64 - 64'd1, 8'd0, 20'd0);
        send_beat(ACT_MUL_BYTE, 64'd0, 8'hFF, 20'd0);
        send_beat(ACT_SHIFT,    64'd0, 8'd0, 20'hFFFFF);
        send_beat(ACT_SHIFT,    64'd0, 8'd0, 20'd38);
        send_beat(ACT_SHIFT,    64'd0, 8'd0, 20'd0);
        send_beat(ACT_MUL_BYTE, 64'd0, 8'd0, 20'd0);
        send_beat(ACT_COMPARE,  64'd0, 8'd0, 20'd0);
        send_beat(ACT_COMPARE,  M64, 8'd0, 20'd0);
        send_beat(ACT_COMPARE,  ALL1, 8'd0, 20'd0);
        drain_results();

        while (sent_count < 25 + RANDOM_ITEMS) begin
            if (sent_count >= 25 + RANDOM_ITEMS - QUIET_ITEMS) begin
                quiet = 1'b1;
            end
            if ($urandom_range(0, 19) == 0) begin
                send_gaps = ~send_gaps;
            end
            if ($urandom_range(0, 59) == 0) begin
                drain_results();
            end
            case ($urandom_range(0, 9))
                0, 1, 2, 3: begin
                    // String hash, now and then rolled forward by a shift.
                    send_beat(ACT_CLEAR, rand_operand(), 8'($urandom), 20'($urandom));
                    n = $urandom_range(1, 12);
                    repeat (n) begin
                        send_beat(ACT_APPEND, rand_operand(), 8'($urandom), 20'($urandom));
                    end
                    if ($urandom_range(0, 2) == 0) begin
                        send_beat(ACT_SHIFT, rand_operand(), 8'($urandom), 20'($urandom));
                        send_beat(ACT_APPEND, rand_operand(), 8'($urandom), 20'($urandom));
                    end
                end
                4, 5: begin
                    // Load, optional add/subtract round trip, then a matching compare.
                    v = rand_operand();
                    w = rand_operand();
                    send_beat(ACT_LOAD, v, 8'($urandom), 20'($urandom));
                    if ($urandom_range(0, 1) == 0) begin
                        send_beat(ACT_ADD, w, 8'($urandom), 20'($urandom));
                        send_beat(ACT_SUB, w, 8'($urandom), 20'($urandom));
                    end
                    send_beat(ACT_COMPARE, v, 8'($urandom), 20'($urandom));
                end
                default: send_random_action();
            endcase
        end

        drain_results();
        repeat (8) @(posedge aclk);
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/m61rh_pkg.sv
rtl/m61rh_prep.sv
rtl/m61rh_alu.sv
rtl/mersenne61_rolling_hash_unit_top.sv
verif/m61rh_hash_checker.sv
verif/mersenne61_rolling_hash_unit_top_tb.sv
